// ===== rtl/srha_pkg.sv =====
package srha_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned CountW = 6;
    localparam int unsigned ColW   = 16;

    localparam logic signed [ValueW-1:0] SumMax = 32'sh7FFF_FFFF;
    localparam logic signed [ValueW-1:0] SumMin = 32'sh8000_0000;

    localparam logic KindAcc   = 1'b0;
    localparam logic KindFlush = 1'b1;

    function automatic logic [ValueW-1:0] sat_add(logic [ValueW-1:0] a,
                                                  logic [ValueW-1:0] b);
        logic [ValueW:0] s;
        s = {a[ValueW-1], a} + {b[ValueW-1], b};
        if (s[ValueW] != s[ValueW-1]) begin
            return s[ValueW] ? SumMin : SumMax;
        end
        return s[ValueW-1:0];
    endfunction

endpackage

// ===== rtl/sparse_row_hash_accumulator_core.sv =====
// Accumulate beat: accept, a hash step, then a read step and a compare step per probed slot
//   (1..TABLE_SLOTS slots probed); not ready meanwhile.
// Flush beat: accept, then per result beat a scan of every slot plus an emit step
//   (held while the output register is still full), then a clear of every slot.
// Reset (synchronous, i_rst_n low) clears control, valid bits, count and the sticky
//   overflow flag; slot column and sum memories are not reset.
module sparse_row_hash_accumulator_core #(
    parameter int unsigned TABLE_SLOTS = 32,
    parameter int unsigned COLUMN_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // column[15:0], value[47:16]
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // out_column[15:0], out_value[47:16],
                                       // valid_entry[48], row_count[54:49],
                                       // overflow[55]
    output logic        m_axis_tlast
);
    localparam int unsigned IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CntW = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned CbW  = (COLUMN_BITS < srha_pkg::ColW) ? COLUMN_BITS
                                                                  : srha_pkg::ColW;
    // Slot hash by reciprocal multiplication: quotient = (col * Recip) >> (ColW + IdxW)
    // is exact for every column below 2**ColW when TABLE_SLOTS is above 1.
    localparam int unsigned QuotW = srha_pkg::ColW + 1 - IdxW;
    localparam int unsigned ProdW = 2 * srha_pkg::ColW + 1;
    localparam logic [srha_pkg::ColW:0] Recip = (srha_pkg::ColW + 1)'(
        ((64'd1 << (srha_pkg::ColW + IdxW)) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_PROBE_RD, S_PROBE, S_SCAN, S_EMIT, S_CLEAR
    } t_state;

    t_state r_state;
    logic [srha_pkg::ColW-1:0]   mem_col [TABLE_SLOTS];
    logic [srha_pkg::ValueW-1:0] mem_sum [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]      r_valid;
    logic [TABLE_SLOTS-1:0]      r_done;     // already emitted during flush
    logic [CntW-1:0]             r_count, r_probes, r_emitted;
    logic                        r_ovf;
    logic [IdxW-1:0]             r_idx, r_best;
    logic                        r_have;
    logic [srha_pkg::ColW-1:0]   r_col, r_best_col, r_rd_col;
    logic [srha_pkg::ValueW-1:0] r_val, r_best_sum, r_rd_sum;
    logic [QuotW-1:0]            r_quot;
    logic                        r_ovalid, r_olast;
    logic [55:0]                 r_odata;

    logic [IdxW-1:0] idx_next, idx_prev;
    logic [srha_pkg::ColW-1:0] col_in;
    logic [ProdW-1:0] hash_prod;
    logic [srha_pkg::ColW-1:0] hash_rem;
    logic emit_go;

    assign idx_next = (r_idx == IdxW'(TABLE_SLOTS - 1)) ? '0 : r_idx + 1'b1;
    assign idx_prev = (r_idx == '0) ? IdxW'(TABLE_SLOTS - 1) : r_idx - 1'b1;
    assign col_in   = srha_pkg::ColW'(s_axis_tdata[CbW-1:0]);

    // Quotient from the incoming column; remainder in the next cycle from the registered quotient
    assign hash_prod = ProdW'(col_in) * ProdW'(Recip);
    assign hash_rem  = r_col - (srha_pkg::ColW'(r_quot) * srha_pkg::ColW'(TABLE_SLOTS));

    // Load the output register when it is empty or being drained this cycle
    assign emit_go = (r_state == S_EMIT) && (!r_ovalid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // Registered memory read at r_idx.
    always_ff @(posedge i_clk) begin
        r_rd_col <= mem_col[r_idx];
        r_rd_sum <= mem_sum[r_idx];
        if (r_state == S_PROBE && r_probes != '0) begin
            if (!r_valid[r_best]) begin
                mem_col[r_best] <= r_col;
                mem_sum[r_best] <= r_val;
            end else if (r_rd_col == r_col) begin
                mem_sum[r_best] <= srha_pkg::sat_add(r_rd_sum, r_val);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_done    <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_ovalid  <= 1'b0;
            r_idx     <= '0;
            r_probes  <= '0;
            r_emitted <= '0;
            r_have    <= 1'b0;
        end else begin
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_col    <= col_in;
                        r_val    <= s_axis_tdata[47:16];
                        r_probes <= '0;
                        if (s_axis_tuser == srha_pkg::KindFlush) begin
                            r_idx     <= '0;
                            r_have    <= 1'b0;
                            r_done    <= '0;
                            r_emitted <= '0;
                            r_state   <= S_SCAN;
                        end else begin
                            r_quot  <= hash_prod[srha_pkg::ColW + IdxW +: QuotW];
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    // home slot = column mod TABLE_SLOTS
                    r_idx   <= IdxW'(hash_rem);
                    r_state <= S_PROBE_RD;
                end
                S_PROBE_RD: begin
                    // issue read at r_idx; data next cycle
                    r_best   <= r_idx;
                    r_idx    <= idx_next;
                    r_probes <= r_probes + 1'b1;
                    r_state  <= S_PROBE;
                end
                S_PROBE: begin
                    // read data holds slot r_best; r_idx already points past it
                    if (!r_valid[r_best]) begin
                        r_valid[r_best] <= 1'b1;
                        r_count <= r_count + 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_rd_col == r_col) begin
                        r_state <= S_IDLE;
                    end else if (r_probes == CntW'(TABLE_SLOTS)) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_PROBE_RD;
                    end
                end
                S_SCAN: begin
                    // walk slots; read data is registered, so it holds slot idx_prev; r_probes counts slots walked
                    r_idx <= idx_next;
                    if (r_probes != '0) begin
                        if (r_valid[idx_prev] && !r_done[idx_prev] &&
                            (!r_have || r_rd_col < r_best_col)) begin
                            r_have     <= 1'b1;
                            r_best     <= idx_prev;
                            r_best_col <= r_rd_col;
                            r_best_sum <= r_rd_sum;
                        end
                    end
                    if (r_probes == CntW'(TABLE_SLOTS)) begin
                        r_state  <= S_EMIT;
                        r_probes <= '0;
                    end else begin
                        r_probes <= r_probes + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_odata  <= {r_ovf, srha_pkg::CountW'(r_count), r_have,
                                     r_have ? r_best_sum : '0,
                                     r_have ? r_best_col : '0};
                        r_olast  <= !r_have || (r_emitted + 1'b1 == r_count);
                        r_idx    <= '0;
                        r_probes <= '0;
                        if (!r_have || (r_emitted + 1'b1 == r_count)) begin
                            r_state <= S_CLEAR;
                        end else begin
                            r_done[r_best] <= 1'b1;
                            r_emitted      <= r_emitted + 1'b1;
                            r_have         <= 1'b0;
                            r_state        <= S_SCAN;
                        end
                    end
                end
                S_CLEAR: begin
                    r_valid[r_idx] <= 1'b0;
                    r_idx          <= idx_next;
                    if (r_idx == IdxW'(TABLE_SLOTS - 1)) begin
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(TABLE_SLOTS)) else $error("count overrun");
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_ovf) && i_rst_n && $past(i_rst_n) |-> r_ovf) else $error("ovf cleared");
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state == S_CLEAR) |-> r_count == '0) else $error("count not cleared");

endmodule
